// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: hdl/pmdd_pkg.sv
// ----------------------------------------------------------------------------
// pmdd_pkg
// Constants and the symbol lookup for the proximity Morse digit decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmdd_pkg;

    // Run counter
    localparam int RUN_COUNT_WIDTH = 16;
    localparam logic [RUN_COUNT_WIDTH-1:0] RUN_MAX = {RUN_COUNT_WIDTH{1'b1}};

    // Register widths
    localparam int NEAR_WIDTH  = 10;
    localparam int FAR_WIDTH   = 10;
    localparam int DASH_WIDTH  = 8;
    localparam int CFG_WIDTH   = 10;
    localparam int CFG_IDX_W   = 2;

    // Comparison width for run length against dash threshold
    localparam int CMP_WIDTH = (RUN_COUNT_WIDTH > DASH_WIDTH) ? RUN_COUNT_WIDTH : DASH_WIDTH;

    // Echo time to centimeters
    localparam int ECHO_WIDTH  = 20;
    localparam int CM_DIVISOR  = 65;
    // Scaled limits: (near + 1) * 65 and far * 65, both up to 17 bits
    localparam int NEAR_SCALED_W = 17;
    localparam int FAR_SCALED_W  = 17;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_THR   = 2'd2;

    // Reset values
    localparam logic [NEAR_WIDTH-1:0] NEAR_RESET = 10'd2;
    localparam logic [FAR_WIDTH-1:0]  FAR_RESET  = 10'd20;
    localparam logic [DASH_WIDTH-1:0] DASH_RESET = 8'd2;

    // Symbols
    localparam int SYM_WIDTH = 5;
    localparam int CNT_WIDTH = 3;
    localparam logic [CNT_WIDTH-1:0] SYMBOLS_PER_DIGIT = 3'd5;
    localparam int DIGIT_WIDTH = 4;
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_NONE = 4'd0;
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_MAX  = 4'd10;

    // Pattern lookup, newest symbol in bit 0, dash = 1
    function automatic logic [DIGIT_WIDTH-1:0] decode_pattern(
        input logic [SYM_WIDTH-1:0] bits
    );
        logic [DIGIT_WIDTH-1:0] d;
        unique case (bits)
            5'b01111: d = 4'd1;
            5'b00111: d = 4'd2;
            5'b00011: d = 4'd3;
            5'b00001: d = 4'd4;
            5'b00000: d = 4'd5;
            5'b10000: d = 4'd6;
            5'b11000: d = 4'd7;
            5'b11100: d = 4'd8;
            5'b11110: d = 4'd9;
            5'b11111: d = 4'd10;
            default:  d = DIGIT_NONE;
        endcase
        return d;
    endfunction

endpackage

// File: hdl/proximity_morse_digit_decoder.sv
// ----------------------------------------------------------------------------
// proximity_morse_digit_decoder
// Decodes hand-held Morse symbols, seen as ultrasonic echo runs, into digits.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in      | sink      | in_valid/in_ready  | button_level, echo_time_us
// out     | source    | out_valid/out_ready| lamp_on, digit_valid, digit, armed
// cfg     | sink      | cfg_wr_en          | cfg_addr, cfg_wdata
//
// One item per cycle sustained unless the output stalls (input register, then
// result register). The decoder state updates as an item moves into the
// result register. Reset clears state and loads register defaults. A stalled
// result holds the input register; new items are still taken while it is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module proximity_morse_digit_decoder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Sample input
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  button_level,
    input  logic [pmdd_pkg::ECHO_WIDTH-1:0]       echo_time_us,
    // Result output
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  lamp_on,
    output logic                                  digit_valid,
    output logic [pmdd_pkg::DIGIT_WIDTH-1:0]      digit,
    output logic                                  armed,
    // Configuration
    input  logic                                  cfg_wr_en,
    input  logic [pmdd_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [pmdd_pkg::CFG_WIDTH-1:0]        cfg_wdata
);

    // Limits kept pre-scaled by 65 so no divide is needed per sample
    logic [pmdd_pkg::NEAR_SCALED_W-1:0] near_scaled_reg;
    logic [pmdd_pkg::FAR_SCALED_W-1:0]  far_scaled_reg;
    logic [pmdd_pkg::DASH_WIDTH-1:0]    dash_thr_reg;
    logic [pmdd_pkg::NEAR_WIDTH:0]      near_plus_one;
    logic [pmdd_pkg::NEAR_SCALED_W-1:0] near_scaled_next;
    logic [pmdd_pkg::FAR_SCALED_W-1:0]  far_scaled_next;

    // Input stage
    logic s1_valid_reg;
    logic s1_button_reg;
    logic s1_present_reg;
    logic present;
    logic advance;

    // Decoder state
    logic                                  armed_reg;
    logic                                  lamp_reg;
    logic [pmdd_pkg::RUN_COUNT_WIDTH-1:0]  run_reg;
    logic [pmdd_pkg::SYM_WIDTH-1:0]        sym_reg;
    logic [pmdd_pkg::CNT_WIDTH-1:0]        cnt_reg;
    logic                                  armed_next;
    logic                                  lamp_next;
    logic [pmdd_pkg::RUN_COUNT_WIDTH-1:0]  run_next;
    logic [pmdd_pkg::SYM_WIDTH-1:0]        sym_next;
    logic [pmdd_pkg::CNT_WIDTH-1:0]        cnt_next;
    logic                                  dvalid_next;
    logic [pmdd_pkg::DIGIT_WIDTH-1:0]      digit_next;
    logic                                  armed_now;
    logic                                  run_ended;
    logic                                  is_dash;

    // Result register
    logic                                  out_valid_reg;
    logic                                  lamp_out_reg;
    logic                                  dvalid_out_reg;
    logic [pmdd_pkg::DIGIT_WIDTH-1:0]      digit_out_reg;
    logic                                  armed_out_reg;

    // Scale limits on write: (near + 1) * 65, far * 65 as shift-and-add
    assign near_plus_one    = {1'b0, cfg_wdata[pmdd_pkg::NEAR_WIDTH-1:0]} + 11'd1;
    assign near_scaled_next = {near_plus_one, 6'b0}
                            + {{(pmdd_pkg::NEAR_SCALED_W-pmdd_pkg::NEAR_WIDTH-1){1'b0}},
                               near_plus_one};
    assign far_scaled_next  = {1'b0, cfg_wdata[pmdd_pkg::FAR_WIDTH-1:0], 6'b0}
                            + {{(pmdd_pkg::FAR_SCALED_W-pmdd_pkg::FAR_WIDTH){1'b0}},
                               cfg_wdata[pmdd_pkg::FAR_WIDTH-1:0]};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_scaled_reg <= pmdd_pkg::NEAR_SCALED_W'((pmdd_pkg::NEAR_RESET + 1)
                                                       * pmdd_pkg::CM_DIVISOR);
            far_scaled_reg  <= pmdd_pkg::FAR_SCALED_W'(pmdd_pkg::FAR_RESET
                                                      * pmdd_pkg::CM_DIVISOR);
            dash_thr_reg    <= pmdd_pkg::DASH_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                pmdd_pkg::REG_NEAR_LIMIT: near_scaled_reg <= near_scaled_next;
                pmdd_pkg::REG_FAR_LIMIT:  far_scaled_reg  <= far_scaled_next;
                pmdd_pkg::REG_DASH_THR:   dash_thr_reg    <= cfg_wdata[pmdd_pkg::DASH_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Presence: near < echo/65 < far  <=>  (near+1)*65 <= echo < far*65
    assign present = ({3'b0, echo_time_us} >= {6'b0, near_scaled_reg})
                  && ({3'b0, echo_time_us} <  {6'b0, far_scaled_reg});

    // Pipeline control
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_button_reg  <= button_level;
            s1_present_reg <= present;
        end
    end

    // Decoder step
    always_comb
    begin
        armed_now   = armed_reg || s1_button_reg;
        armed_next  = armed_now;
        lamp_next   = lamp_reg;
        run_next    = run_reg;
        sym_next    = sym_reg;
        cnt_next    = cnt_reg;
        dvalid_next = 1'b0;
        digit_next  = pmdd_pkg::DIGIT_NONE;
        run_ended   = 1'b0;
        is_dash     = pmdd_pkg::CMP_WIDTH'(run_reg) > pmdd_pkg::CMP_WIDTH'(dash_thr_reg);

        if (armed_now)
        begin
            if (s1_present_reg)
            begin
                lamp_next = 1'b1;
                if (run_reg != pmdd_pkg::RUN_MAX)
                begin
                    run_next = run_reg + 1'b1;
                end
            end
            else
            begin
                lamp_next = 1'b0;
                run_ended = (run_reg != '0);
                run_next  = '0;
            end

            if (run_ended)
            begin
                sym_next = {sym_reg[pmdd_pkg::SYM_WIDTH-2:0], is_dash};
                cnt_next = cnt_reg + 1'b1;
            end

            if (cnt_next >= pmdd_pkg::SYMBOLS_PER_DIGIT)
            begin
                dvalid_next = 1'b1;
                digit_next  = pmdd_pkg::decode_pattern(sym_next);
                sym_next    = '0;
                cnt_next    = '0;
                armed_next  = 1'b0;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            lamp_reg  <= 1'b0;
            run_reg   <= '0;
            sym_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (advance)
        begin
            armed_reg <= armed_next;
            lamp_reg  <= lamp_next;
            run_reg   <= run_next;
            sym_reg   <= sym_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lamp_out_reg   <= lamp_next;
            dvalid_out_reg <= dvalid_next;
            digit_out_reg  <= digit_next;
            armed_out_reg  <= armed_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign lamp_on     = lamp_out_reg;
    assign digit_valid = dvalid_out_reg;
    assign digit       = digit_out_reg;
    assign armed       = armed_out_reg;

    // Checks
    `ASSERT_NEVER(a_cnt_below_five, clk, rst_n, cnt_reg >= pmdd_pkg::SYMBOLS_PER_DIGIT)
    `ASSERT_PROP(a_digit_disarms, clk, rst_n, (advance && dvalid_next) |=> !armed_reg)
    `ASSERT_PROP(a_advance_fills_out, clk, rst_n, advance |=> out_valid_reg)
    `ASSERT_NEVER(a_digit_range, clk, rst_n, advance && (digit_next > pmdd_pkg::DIGIT_MAX))
    `ASSERT_PROP(a_idle_holds, clk, rst_n,
        (advance && !armed_reg && !s1_button_reg) |=> ($stable(run_reg) && $stable(lamp_reg)))

endmodule
